// ===== src/circle_circle_aabb_contact_test_macros.svh =====
// ============================================================================
// circle_circle_aabb_contact_test assertion macros
// shared property forms for the contact test checks
// ============================================================================
`ifndef CIRCLE_CIRCLE_AABB_CONTACT_TEST_MACROS_SVH
`define CIRCLE_CIRCLE_AABB_CONTACT_TEST_MACROS_SVH

// same-cycle implication, quiet during reset
`define CCAT_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("contact test check failed");

// next-cycle implication, quiet during reset
`define CCAT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("contact test check failed");

`endif

// ===== src/ccat_pkg.sv =====
// ============================================================================
// ccat_pkg
// widths, codes and helpers of the circle / box contact test
// ============================================================================
package ccat_pkg;

  localparam int COORD_BITS  = 24;
  localparam int VW          = COORD_BITS + 1;
  localparam int SQ_W        = 2 * VW;
  localparam int RAD_W       = SQ_W + 2;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int NORM_FRAC   = 14;
  localparam int NORM_W      = 16;
  localparam int QUOT_W      = NORM_FRAC + 1;
  localparam int DIV_STAGES  = QUOT_W;
  localparam int NUM_W       = VW + NORM_FRAC + 1;
  localparam int PROD_W      = QUOT_W + COORD_BITS;
  localparam int LIMIT_W     = 8;

  localparam logic [QUOT_W-1:0] NORM_ONE  = QUOT_W'(1) << NORM_FRAC;
  localparam logic [PROD_W-1:0] NORM_HALF = PROD_W'(1) << (NORM_FRAC - 1);

  localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [1:0] SHAPE_RECT   = 2'd1;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CC   = 2'd1;
  localparam logic [1:0] KIND_CR   = 2'd2;

  typedef logic signed [VW-1:0] vec_t;

  typedef struct packed {
    logic [1:0]            shape_a;
    logic [COORD_BITS-1:0] pos_a_x;
    logic [COORD_BITS-1:0] pos_a_y;
    logic [COORD_BITS-1:0] pos_a_z;
    logic [COORD_BITS-1:0] dim_a_first;
    logic [COORD_BITS-1:0] dim_a_second;
    logic [1:0]            shape_b;
    logic [COORD_BITS-1:0] pos_b_x;
    logic [COORD_BITS-1:0] pos_b_y;
    logic [COORD_BITS-1:0] pos_b_z;
    logic [COORD_BITS-1:0] dim_b_first;
    logic [COORD_BITS-1:0] dim_b_second;
  } raw_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  swap;
    vec_t                  pc_x;
    vec_t                  pc_y;
    vec_t                  pc_z;
    logic [COORD_BITS-1:0] ra;
    logic [VW-1:0]         rad;
    vec_t                  pr_x;
    vec_t                  pr_y;
    vec_t                  pr_z;
    vec_t                  lo_x;
    vec_t                  hi_x;
    vec_t                  lo_y;
    vec_t                  hi_y;
    vec_t                  q_x;
    vec_t                  q_y;
    vec_t                  d_x;
    vec_t                  d_y;
    vec_t                  d_z;
    vec_t                  t_x;
    vec_t                  t_y;
    vec_t                  t_z;
    logic                  tol;
    logic                  hit;
    logic                  nrm;
    logic [2:0]            sgn;
    logic [VW-1:0]         depth;
  } ctx_t;

  function automatic vec_t sx(input logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic [VW-1:0] mag(input vec_t v);
    logic [VW-1:0] u;
    u = v;
    return v[VW-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

// ===== src/ccat_sqrt.sv =====
// ============================================================================
// ccat_sqrt
// pipelined integer square root, one result bit per stage
// ============================================================================
module ccat_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ccat_pkg::RAD_W-1:0]  rad,
  output logic [ccat_pkg::ROOT_W-1:0] root
);
  import ccat_pkg::*;

  logic [RAD_W-1:0]  rem_d  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_d [SQRT_STAGES];
  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  assign rem_d[0]  = rad;
  assign root_d[0] = '0;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - s;
    logic [RAD_W+1:0] trial;

    if (s > 0) begin : g_link
      assign rem_d[s]  = rem_q[s-1];
      assign root_d[s] = root_q[s-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((RAD_W + 2)'(root_d[s]) << (B + 1)) + ((RAD_W + 2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rem_d[s]} >= trial) begin
          rem_q[s]  <= rem_d[s] - trial[RAD_W-1:0];
          root_q[s] <= root_d[s] | (ROOT_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_d[s];
          root_q[s] <= root_d[s];
        end
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

// ===== src/ccat_div.sv =====
// ============================================================================
// ccat_div
// pipelined restoring divider, one quotient bit per stage
// ============================================================================
module ccat_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ccat_pkg::NUM_W-1:0]  num,
  input  logic [ccat_pkg::ROOT_W-1:0] den,
  output logic [ccat_pkg::QUOT_W-1:0] quot
);
  import ccat_pkg::*;

  logic [NUM_W-1:0]  rem_d  [DIV_STAGES];
  logic [ROOT_W-1:0] den_d  [DIV_STAGES];
  logic [QUOT_W-1:0] quot_d [DIV_STAGES];
  logic [NUM_W-1:0]  rem_q  [DIV_STAGES];
  logic [ROOT_W-1:0] den_q  [DIV_STAGES];
  logic [QUOT_W-1:0] quot_q [DIV_STAGES];

  assign rem_d[0]  = num;
  assign den_d[0]  = den;
  assign quot_d[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - s;
    logic [NUM_W:0] dsh;

    if (s > 0) begin : g_link
      assign rem_d[s]  = rem_q[s-1];
      assign den_d[s]  = den_q[s-1];
      assign quot_d[s] = quot_q[s-1];
    end

    assign dsh = (NUM_W + 1)'(den_d[s]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[s] <= den_d[s];
        if ({1'b0, rem_d[s]} >= dsh) begin
          rem_q[s]  <= rem_d[s] - dsh[NUM_W-1:0];
          quot_q[s] <= quot_d[s] | (QUOT_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_d[s];
          quot_q[s] <= quot_d[s];
        end
      end
    end
  end

  assign quot = quot_q[DIV_STAGES-1];

endmodule

// ===== src/circle_circle_aabb_contact_test.sv =====
// ============================================================================
// circle_circle_aabb_contact_test
// narrow-phase contact test for one body pair per transaction
// ============================================================================
// usage
//   input channel: in_valid / in_stall carries one body pair (shapes, centres,
//   extents); output channel: out_valid / out_stall carries one contact result
//   per pair (hit, order_swapped, depth, point, normal).
//   config channel: cfg_valid / cfg_ready writes small_limit; cfg_ready is
//   always high; write it only while no pair is in flight.
// stages and throughput
//   an accepted pair passes 5 front stages (capture, decode, clamp, square,
//   sum), 26 square-root stages, one select stage, 15 divider stages, one
//   scaling stage and the output register.
//   one pair per cycle is taken while the output is not stalled.
// reset
//   rst clears every stage valid, the output valid and small_limit.
// stall
//   out_stall holding a valid result freezes the whole pipeline; in_stall
//   follows it combinationally, so nothing is dropped or repeated.
// ============================================================================
`include "circle_circle_aabb_contact_test_macros.svh"

module circle_circle_aabb_contact_test (
  input  logic                                  clk,
  input  logic                                  rst,
  // config channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ccat_pkg::LIMIT_W-1:0]          cfg_data,
  // pair channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            shape_a,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_a_x,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_a_y,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_a_z,
  input  logic [ccat_pkg::COORD_BITS-1:0]       dim_a_first,
  input  logic [ccat_pkg::COORD_BITS-1:0]       dim_a_second,
  input  logic [1:0]                            shape_b,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_b_x,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_b_y,
  input  logic signed [ccat_pkg::COORD_BITS-1:0] pos_b_z,
  input  logic [ccat_pkg::COORD_BITS-1:0]       dim_b_first,
  input  logic [ccat_pkg::COORD_BITS-1:0]       dim_b_second,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  hit,
  output logic                                  order_swapped,
  output logic [ccat_pkg::VW-1:0]               depth,
  output logic signed [ccat_pkg::VW-1:0]        point_x,
  output logic signed [ccat_pkg::VW-1:0]        point_y,
  output logic signed [ccat_pkg::VW-1:0]        point_z,
  output logic signed [ccat_pkg::NORM_W-1:0]    normal_x,
  output logic signed [ccat_pkg::NORM_W-1:0]    normal_y,
  output logic signed [ccat_pkg::NORM_W-1:0]    normal_z
);
  import ccat_pkg::*;

  // global advance: the whole pipe moves unless a held result is stalled
  logic adv;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // tolerance register
  logic [LIMIT_W-1:0] small_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit <= '0;
    end else if (cfg_valid) begin
      small_limit <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture the pair
  // --------------------------------------------------------------------------
  raw_t raw_q;
  logic vld1;
  always_ff @(posedge clk) begin
    if (adv) begin
      raw_q <= '{shape_a, pos_a_x, pos_a_y, pos_a_z, dim_a_first, dim_a_second,
                 shape_b, pos_b_x, pos_b_y, pos_b_z, dim_b_first, dim_b_second};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: decode the pair kind, pick circle and box, box bounds
  // --------------------------------------------------------------------------
  ctx_t ctx2_next, ctx2;
  logic vld2;

  always_comb begin
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [VW-1:0]         hw;
    logic [VW-1:0]         hh;
    ctx2_next = '0;
    w = raw_q.dim_b_first;
    h = raw_q.dim_b_second;
    if (raw_q.shape_a == SHAPE_CIRCLE && raw_q.shape_b == SHAPE_CIRCLE) begin
      ctx2_next.kind = KIND_CC;
    end else if (raw_q.shape_a == SHAPE_CIRCLE && raw_q.shape_b == SHAPE_RECT) begin
      ctx2_next.kind = KIND_CR;
    end else if (raw_q.shape_a == SHAPE_RECT && raw_q.shape_b == SHAPE_CIRCLE) begin
      ctx2_next.kind = KIND_CR;
      ctx2_next.swap = 1'b1;
    end else begin
      ctx2_next.kind = KIND_NONE;
    end

    if (ctx2_next.swap) begin
      // circle is body b, box is body a
      ctx2_next.pc_x = sx(raw_q.pos_b_x);
      ctx2_next.pc_y = sx(raw_q.pos_b_y);
      ctx2_next.pc_z = sx(raw_q.pos_b_z);
      ctx2_next.pr_x = sx(raw_q.pos_a_x);
      ctx2_next.pr_y = sx(raw_q.pos_a_y);
      ctx2_next.pr_z = sx(raw_q.pos_a_z);
      ctx2_next.ra   = raw_q.dim_b_first;
      w = raw_q.dim_a_first;
      h = raw_q.dim_a_second;
    end else begin
      ctx2_next.pc_x = sx(raw_q.pos_a_x);
      ctx2_next.pc_y = sx(raw_q.pos_a_y);
      ctx2_next.pc_z = sx(raw_q.pos_a_z);
      ctx2_next.pr_x = sx(raw_q.pos_b_x);
      ctx2_next.pr_y = sx(raw_q.pos_b_y);
      ctx2_next.pr_z = sx(raw_q.pos_b_z);
      ctx2_next.ra   = raw_q.dim_a_first;
    end

    // radius sum for two circles, plain radius against a box
    if (ctx2_next.kind == KIND_CC) begin
      ctx2_next.rad = VW'(raw_q.dim_a_first) + VW'(raw_q.dim_b_first);
    end else begin
      ctx2_next.rad = VW'(ctx2_next.ra);
    end

    // half extents truncated to q.8
    hw = VW'(w >> 1);
    hh = VW'(h >> 1);
    ctx2_next.lo_x = ctx2_next.pr_x - vec_t'(hw);
    ctx2_next.hi_x = ctx2_next.pr_x + vec_t'(hw);
    ctx2_next.lo_y = ctx2_next.pr_y - vec_t'(hh);
    ctx2_next.hi_y = ctx2_next.pr_y + vec_t'(hh);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx2 <= ctx2_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: clamp to the box, difference vectors
  // --------------------------------------------------------------------------
  ctx_t ctx3_next, ctx3;
  logic vld3;

  always_comb begin
    ctx3_next = ctx2;
    ctx3_next.q_x = (ctx2.pc_x < ctx2.lo_x) ? ctx2.lo_x :
                    ((ctx2.pc_x > ctx2.hi_x) ? ctx2.hi_x : ctx2.pc_x);
    ctx3_next.q_y = (ctx2.pc_y < ctx2.lo_y) ? ctx2.lo_y :
                    ((ctx2.pc_y > ctx2.hi_y) ? ctx2.hi_y : ctx2.pc_y);
    // box centre to circle centre, fallback direction
    ctx3_next.t_x = ctx2.pc_x - ctx2.pr_x;
    ctx3_next.t_y = ctx2.pc_y - ctx2.pr_y;
    ctx3_next.t_z = ctx2.pc_z - ctx2.pr_z;
    if (ctx2.kind == KIND_CC) begin
      // a to b
      ctx3_next.d_x = ctx2.pr_x - ctx2.pc_x;
      ctx3_next.d_y = ctx2.pr_y - ctx2.pc_y;
      ctx3_next.d_z = ctx2.pr_z - ctx2.pc_z;
    end else begin
      // clamped point to circle centre, flat in z
      ctx3_next.d_x = ctx2.pc_x - ctx3_next.q_x;
      ctx3_next.d_y = ctx2.pc_y - ctx3_next.q_y;
      ctx3_next.d_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3 <= ctx3_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squares of both vectors
  // --------------------------------------------------------------------------
  ctx_t ctx4;
  logic vld4;
  logic [SQ_W-1:0] sqd [3];
  logic [SQ_W-1:0] sqt [3];
  logic [VW-1:0]   md  [3];
  logic [VW-1:0]   mt  [3];

  assign md[0] = mag(ctx3.d_x);
  assign md[1] = mag(ctx3.d_y);
  assign md[2] = mag(ctx3.d_z);
  assign mt[0] = mag(ctx3.t_x);
  assign mt[1] = mag(ctx3.t_y);
  assign mt[2] = mag(ctx3.t_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4 <= ctx3;
      for (int i = 0; i < 3; i++) begin
        sqd[i] <= md[i] * md[i];
        sqt[i] <= mt[i] * mt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: sums of squares, tolerance check on the fallback length
  // --------------------------------------------------------------------------
  ctx_t ctx5, ctx5_next;
  logic vld5;
  logic [RAD_W-1:0] sum_d_next, sum_t_next, sum_d, sum_t;

  always_comb begin
    sum_d_next = RAD_W'(sqd[0]) + RAD_W'(sqd[1]) + RAD_W'(sqd[2]);
    sum_t_next = RAD_W'(sqt[0]) + RAD_W'(sqt[1]) + RAD_W'(sqt[2]);
    ctx5_next = ctx4;
    ctx5_next.tol = (sum_t_next <= RAD_W'({small_limit, 8'h00}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx5  <= ctx5_next;
      sum_d <= sum_d_next;
      sum_t <= sum_t_next;
    end
  end

  // --------------------------------------------------------------------------
  // square roots, context rides alongside
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] dist_d, dist_t;
  ctx_t sq_ctx [SQRT_STAGES];
  logic sq_vld [SQRT_STAGES];

  ccat_sqrt u_sqrt_d (.clk(clk), .en(adv), .rad(sum_d), .root(dist_d));
  ccat_sqrt u_sqrt_t (.clk(clk), .en(adv), .rad(sum_t), .root(dist_t));

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctx[0] <= ctx5;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sq_ctx[i] <= sq_ctx[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // select stage: hit test, pick the normal source, build dividends
  // --------------------------------------------------------------------------
  ctx_t ctx6, ctx6_next;
  logic vld6;
  logic [NUM_W-1:0]  num_next [3];
  logic [NUM_W-1:0]  num_q    [3];
  logic [ROOT_W-1:0] len_next, len_q;

  always_comb begin
    ctx_t c;
    logic use_d;
    vec_t v [3];
    c = sq_ctx[SQRT_STAGES-1];
    ctx6_next = c;
    use_d = (dist_d > ROOT_W'(small_limit));
    ctx6_next.hit = (c.kind != KIND_NONE) && (dist_d < ROOT_W'(c.rad));
    ctx6_next.nrm = use_d || (c.kind == KIND_CR && !c.tol);
    ctx6_next.depth = c.rad - VW'(dist_d);
    if (use_d) begin
      v[0] = c.d_x;
      v[1] = c.d_y;
      v[2] = c.d_z;
      len_next = dist_d;
    end else begin
      v[0] = c.t_x;
      v[1] = c.t_y;
      v[2] = c.t_z;
      len_next = dist_t;
    end
    for (int i = 0; i < 3; i++) begin
      ctx6_next.sgn[i] = v[i][VW-1];
      // round to nearest: add half the length before dividing
      num_next[i] = (NUM_W'(mag(v[i])) << NORM_FRAC) + NUM_W'(len_next >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx6  <= ctx6_next;
      len_q <= len_next;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= num_next[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // normal division, three lanes
  // --------------------------------------------------------------------------
  logic [QUOT_W-1:0] quot [3];
  ctx_t dv_ctx [DIV_STAGES];
  logic dv_vld [DIV_STAGES];

  for (genvar i = 0; i < 3; i++) begin : g_div
    ccat_div u_div (.clk(clk), .en(adv), .num(num_q[i]), .den(len_q), .quot(quot[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx[0] <= ctx6;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_ctx[i] <= dv_ctx[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // scaling stage: signed normal and normal times radius
  // --------------------------------------------------------------------------
  ctx_t ctx7;
  logic vld7;
  logic signed [NORM_W-1:0] nrm_next [3];
  logic signed [NORM_W-1:0] nrm_q    [3];
  logic [QUOT_W-1:0]        nmag     [3];
  logic [PROD_W-1:0]        prod_q   [3];

  always_comb begin
    ctx_t c;
    c = dv_ctx[DIV_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      if (c.nrm) begin
        nmag[i]     = quot[i];
        nrm_next[i] = c.sgn[i] ? -NORM_W'(quot[i]) : NORM_W'(quot[i]);
      end else begin
        // default +x
        nmag[i]     = (i == 0) ? NORM_ONE : '0;
        nrm_next[i] = NORM_W'(nmag[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx7 <= dv_ctx[DIV_STAGES-1];
      for (int i = 0; i < 3; i++) begin
        nrm_q[i]  <= nrm_next[i];
        prod_q[i] <= PROD_W'(nmag[i]) * PROD_W'(dv_ctx[DIV_STAGES-1].ra);
      end
    end
  end

  // --------------------------------------------------------------------------
  // output stage: hit point, saturation, zeroing on a miss
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] pt_next [3];

  always_comb begin
    logic [PROD_W-1:0]       rnd;
    logic [VW-1:0]           m;
    logic signed [VW+1:0]    s;
    vec_t                    base [3];
    base[0] = ctx7.pc_x;
    base[1] = ctx7.pc_y;
    base[2] = ctx7.pc_z;
    for (int i = 0; i < 3; i++) begin
      rnd = prod_q[i] + NORM_HALF;
      m   = VW'(rnd >> NORM_FRAC);
      s   = (VW + 2)'(base[i]) + (nrm_q[i][NORM_W-1] ? -(VW + 2)'({2'b00, m})
                                                      : (VW + 2)'({2'b00, m}));
      // clip to the signed point range
      if (s > (VW + 2)'((1 << (VW - 1)) - 1)) begin
        pt_next[i] = {1'b0, {(VW - 1){1'b1}}};
      end else if (s < -(VW + 2)'(1 << (VW - 1))) begin
        pt_next[i] = {1'b1, {(VW - 1){1'b0}}};
      end else begin
        pt_next[i] = s[VW-1:0];
      end
    end
    if (ctx7.kind == KIND_CR) begin
      pt_next[0] = ctx7.q_x;
      pt_next[1] = ctx7.q_y;
      pt_next[2] = ctx7.pc_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit           <= ctx7.hit;
      order_swapped <= ctx7.hit && ctx7.swap;
      depth         <= ctx7.hit ? ctx7.depth : '0;
      point_x       <= ctx7.hit ? pt_next[0] : '0;
      point_y       <= ctx7.hit ? pt_next[1] : '0;
      point_z       <= ctx7.hit ? pt_next[2] : '0;
      normal_x      <= ctx7.hit ? nrm_q[0] : '0;
      normal_y      <= ctx7.hit ? nrm_q[1] : '0;
      normal_z      <= ctx7.hit ? nrm_q[2] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // stage valids, cleared by reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      vld6      <= 1'b0;
      vld7      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SQRT_STAGES; i++) begin
        sq_vld[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      sq_vld[0] <= vld5;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sq_vld[i] <= sq_vld[i-1];
      end
      vld6      <= sq_vld[SQRT_STAGES-1];
      dv_vld[0] <= vld6;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_vld[i] <= dv_vld[i-1];
      end
      vld7      <= dv_vld[DIV_STAGES-1];
      out_valid <= vld7;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `CCAT_ASSERT_IMPL(a_miss_is_zero, out_valid && !hit, depth == '0 && !order_swapped && normal_x == '0 && point_x == '0)
  `CCAT_ASSERT_IMPL(a_hit_has_depth, out_valid && hit, depth != '0)
  `CCAT_ASSERT_IMPL(a_normal_bounded, out_valid && hit, normal_x <= 16'sd16384 && normal_x >= -16'sd16384 && normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
  `CCAT_ASSERT_NEXT(a_stall_freezes_pipe, out_valid && out_stall && !rst, $stable(vld7) && $stable(ctx7.hit))

endmodule

// ===== dv/circle_circle_aabb_contact_test_tb.sv =====
// ============================================================================
// circle_circle_aabb_contact_test_tb
// self-checking bench for the circle / box narrow-phase contact test
// ============================================================================
// a directed table goes first: extremes, every shape pairing, coincident
// centres, a centre on the box. Its expected result is typed in where it is
// obvious and predicted otherwise. Random pairs follow, mostly near-touching
// bodies with random content and some pure noise. Each accepted pair is
// predicted in the bench and each accepted result is checked against the
// oldest prediction. The run goes through four handshake pressure phases,
// and small_limit is rewritten between phases while the pipeline is empty.
// ============================================================================
module circle_circle_aabb_contact_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccat_pkg::*;

  // shape codes with no meaning to the block
  localparam logic [1:0] SHAPE_OTHER   = 2'd2;
  localparam logic [1:0] SHAPE_UNUSED  = 2'd3;
  localparam int         DRAIN_CYCLES  = 60;    // longer than the pipeline latency
  localparam int         WATCHDOG_MAX  = 20000;
  localparam int         ITEMS_PER_PHASE = 185;

  typedef struct packed {
    logic                     hit;
    logic                     swp;
    logic [VW-1:0]            depth;
    logic signed [VW-1:0]     px;
    logic signed [VW-1:0]     py;
    logic signed [VW-1:0]     pz;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } contact_t;

  typedef struct {
    raw_t     pair;
    bit       typed;
    contact_t want;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  raw_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit, order_swapped;
  logic [VW-1:0] depth;
  logic signed [VW-1:0] point_x, point_y, point_z;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circle_circle_aabb_contact_test u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .shape_a(drv.shape_a), .pos_a_x(drv.pos_a_x), .pos_a_y(drv.pos_a_y),
    .pos_a_z(drv.pos_a_z), .dim_a_first(drv.dim_a_first),
    .dim_a_second(drv.dim_a_second),
    .shape_b(drv.shape_b), .pos_b_x(drv.pos_b_x), .pos_b_y(drv.pos_b_y),
    .pos_b_z(drv.pos_b_z), .dim_b_first(drv.dim_b_first),
    .dim_b_second(drv.dim_b_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .order_swapped(order_swapped), .depth(depth),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  // ---------------------------------------------------------------- predictor

  // floor square root, result always below 2^27 here
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // component / length in Q1.14, halves away from zero
  function automatic longint to_unit(longint c, longint unsigned len);
    longint unsigned m, q;
    m = (c < 0) ? -c : c;
    q = (m * 16384 + len / 2) / len;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Q1.14 normal times a Q.8 radius, back to Q.8
  function automatic longint along_normal(longint n, longint unsigned r);
    longint unsigned m;
    m = ((((n < 0) ? -n : n)) * r + 8192) >> 14;
    return (n < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [VW-1:0] sat_point(longint v);
    longint top, bot;
    top = (longint'(1) << COORD_BITS) - 1;
    bot = -(longint'(1) << COORD_BITS);
    return VW'((v > top) ? top : ((v < bot) ? bot : v));
  endfunction

  function automatic longint coord(logic [COORD_BITS-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic contact_t circle_vs_box(bit swp, longint cx, longint cy, longint cz,
      longint unsigned rad, longint bx, longint by, longint bz,
      longint unsigned w, longint unsigned h, logic [LIMIT_W-1:0] lim);
    contact_t c;
    longint hw, hh, qx, qy, dx, dy, tx, ty, tz, nx, ny, nz;
    longint unsigned dlen, sq, len;
    c = '0;
    hw = longint'(w >> 1);
    hh = longint'(h >> 1);
    qx = (cx < bx - hw) ? bx - hw : ((cx > bx + hw) ? bx + hw : cx);
    qy = (cy < by - hh) ? by - hh : ((cy > by + hh) ? by + hh : cy);
    dx = cx - qx;
    dy = cy - qy;
    dlen = floor_sqrt(dx * dx + dy * dy);
    if (dlen >= rad) return c;
    nx = 16384; ny = 0; nz = 0;
    if (dlen > lim) begin
      nx = to_unit(dx, dlen);
      ny = to_unit(dy, dlen);
    end else begin
      // centre on the box: fall back to box centre towards circle centre
      tx = cx - bx; ty = cy - by; tz = cz - bz;
      sq = tx * tx + ty * ty + tz * tz;
      if (sq > (longint'(lim) << 8)) begin
        len = floor_sqrt(sq);
        nx = to_unit(tx, len);
        ny = to_unit(ty, len);
        nz = to_unit(tz, len);
      end
    end
    c.hit = 1'b1;
    c.swp = swp;
    c.depth = VW'(rad - dlen);
    c.px = sat_point(qx);
    c.py = sat_point(qy);
    c.pz = sat_point(cz);
    c.nx = NORM_W'(nx); c.ny = NORM_W'(ny); c.nz = NORM_W'(nz);
    return c;
  endfunction

  function automatic contact_t predict_contact(raw_t p, logic [LIMIT_W-1:0] lim);
    contact_t c;
    longint ax, ay, az, bx, by, bz, dx, dy, dz, nx, ny, nz;
    longint unsigned dlen, rsum;
    c = '0;
    ax = coord(p.pos_a_x); ay = coord(p.pos_a_y); az = coord(p.pos_a_z);
    bx = coord(p.pos_b_x); by = coord(p.pos_b_y); bz = coord(p.pos_b_z);
    if (p.shape_a == SHAPE_CIRCLE && p.shape_b == SHAPE_CIRCLE) begin
      dx = bx - ax; dy = by - ay; dz = bz - az;
      dlen = floor_sqrt(dx * dx + dy * dy + dz * dz);
      rsum = longint'(p.dim_a_first) + longint'(p.dim_b_first);
      if (dlen < rsum) begin
        nx = 16384; ny = 0; nz = 0;
        if (dlen > lim) begin
          nx = to_unit(dx, dlen);
          ny = to_unit(dy, dlen);
          nz = to_unit(dz, dlen);
        end
        c.hit = 1'b1;
        c.depth = VW'(rsum - dlen);
        c.px = sat_point(ax + along_normal(nx, p.dim_a_first));
        c.py = sat_point(ay + along_normal(ny, p.dim_a_first));
        c.pz = sat_point(az + along_normal(nz, p.dim_a_first));
        c.nx = NORM_W'(nx); c.ny = NORM_W'(ny); c.nz = NORM_W'(nz);
      end
    end else if (p.shape_a == SHAPE_CIRCLE && p.shape_b == SHAPE_RECT) begin
      c = circle_vs_box(1'b0, ax, ay, az, p.dim_a_first, bx, by, bz,
                        p.dim_b_first, p.dim_b_second, lim);
    end else if (p.shape_a == SHAPE_RECT && p.shape_b == SHAPE_CIRCLE) begin
      c = circle_vs_box(1'b1, bx, by, bz, p.dim_b_first, ax, ay, az,
                        p.dim_a_first, p.dim_a_second, lim);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- monitor

  pair_row_t row_q[$];       // rows presented, in order, waiting for acceptance
  contact_t  contact_q[$];   // expected contacts, oldest first
  logic [LIMIT_W-1:0] limit_now = '0;
  int accepted_pairs = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    contact_t got, want;
    pair_row_t row;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (cfg_valid && cfg_ready) limit_now = cfg_data;
      if (in_valid && !in_stall) begin
        row = row_q.pop_front();
        contact_q.push_back(row.typed ? row.want : predict_contact(drv, limit_now));
        accepted_pairs = accepted_pairs + 1;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got = '{hit, order_swapped, depth, point_x, point_y, point_z,
                normal_x, normal_y, normal_z};
        if (contact_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = contact_q.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("circle_circle_aabb_contact_test test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- pressure

  int sender_idle_pct = 0;
  int stall_pct = 0;

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- stimulus

  task automatic send_pair(raw_t p, bit typed, contact_t want);
    int seen;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    row_q.push_back('{p, typed, want});
    drv = p;
    in_valid = 1'b1;
    seen = accepted_pairs;
    do @(negedge clk); while (accepted_pairs == seen);
  endtask

  // pipeline empty, then enough cycles for anything still inside
  task automatic drain();
    in_valid = 1'b0;
    while (contact_q.size() != 0 || row_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic raw_t noise_pair();
    raw_t p;
    p = raw_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                20'($urandom)});
    return p;
  endfunction

  // bodies placed near each other so that hits and near misses are common
  function automatic raw_t close_pair();
    raw_t p;
    int span, sel;
    int ax, ay, az;
    p = noise_pair();
    sel = $urandom_range(9);
    p.shape_a = (sel < 4) ? SHAPE_CIRCLE : (sel < 7) ? SHAPE_CIRCLE : (sel < 9) ? SHAPE_RECT
              : 2'($urandom);
    p.shape_b = (sel < 4) ? SHAPE_CIRCLE : (sel < 7) ? SHAPE_RECT : (sel < 9) ? SHAPE_CIRCLE
              : 2'($urandom);
    // sizes mostly small, now and then huge
    span = ($urandom_range(15) == 0) ? 24'hFFFFFF : (1 << $urandom_range(14, 2));
    p.dim_a_first  = COORD_BITS'($urandom_range(span));
    p.dim_a_second = COORD_BITS'($urandom_range(span));
    p.dim_b_first  = COORD_BITS'($urandom_range(span));
    p.dim_b_second = COORD_BITS'($urandom_range(span));
    ax = $signed(p.pos_a_x);
    ay = $signed(p.pos_a_y);
    az = $signed(p.pos_a_z);
    // sometimes nearly coincident, to reach the tolerance paths
    if ($urandom_range(4) == 0) span = 4;
    p.pos_b_x = COORD_BITS'(ax + $signed($urandom_range(2 * span)) - span);
    p.pos_b_y = COORD_BITS'(ay + $signed($urandom_range(2 * span)) - span);
    p.pos_b_z = COORD_BITS'(az + $signed($urandom_range(2 * span)) - span);
    return p;
  endfunction

  function automatic raw_t make_pair(logic [1:0] sa, int ax, int ay, int az, int a1, int a2,
                                     logic [1:0] sb, int bx, int by, int bz, int b1, int b2);
    return '{sa, COORD_BITS'(ax), COORD_BITS'(ay), COORD_BITS'(az),
             COORD_BITS'(a1), COORD_BITS'(a2),
             sb, COORD_BITS'(bx), COORD_BITS'(by), COORD_BITS'(bz),
             COORD_BITS'(b1), COORD_BITS'(b2)};
  endfunction

  pair_row_t directed[$];

  initial begin
    contact_t none_c, unit_x;
    logic [LIMIT_W-1:0] limits[4];
    int idle_set, stall_set;
    none_c = '0;
    // a plain +x contact, filled per row
    unit_x = '0;

    // table: shape pairs, extremes and the special cases
    directed.push_back('{make_pair(SHAPE_RECT, 0, 0, 0, 512, 512,
                                   SHAPE_RECT, 0, 0, 0, 512, 512), 1, none_c});
    directed.push_back('{make_pair(SHAPE_OTHER, 0, 0, 0, 512, 512,
                                   SHAPE_CIRCLE, 0, 0, 0, 512, 512), 1, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, 0, 0, 0, 512, 512,
                                   SHAPE_UNUSED, 0, 0, 0, 512, 512), 1, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, -8388608, 0, 0, 256, 0,
                                   SHAPE_CIRCLE, 8388607, 0, 0, 256, 0), 1, none_c});
    // coincident centres: normal +x, depth is the radius sum
    unit_x = '{1'b1, 1'b0, 25'd512, 25'sd256, 25'sd0, 25'sd0, 16'sd16384, 16'sd0, 16'sd0};
    directed.push_back('{make_pair(SHAPE_CIRCLE, 0, 0, 0, 256, 0,
                                   SHAPE_CIRCLE, 0, 0, 0, 256, 0), 1, unit_x});
    // largest radii at the top corner: point saturates
    unit_x = '{1'b1, 1'b0, 25'h1FFFFFE, 25'sd16777215, 25'sd8388607, 25'sd8388607,
               16'sd16384, 16'sd0, 16'sd0};
    directed.push_back('{make_pair(SHAPE_CIRCLE, 8388607, 8388607, 8388607, 24'hFFFFFF, 0,
                                   SHAPE_CIRCLE, 8388607, 8388607, 8388607, 24'hFFFFFF, 0),
                         1, unit_x});
    directed.push_back('{make_pair(SHAPE_CIRCLE, -8388608, -8388608, -8388608, 24'hFFFFFF,
                                   24'hFFFFFF, SHAPE_CIRCLE, 8388607, 8388607, 8388607,
                                   24'hFFFFFF, 24'hFFFFFF), 0, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, 0, 0, 0, 1000, 0,
                                   SHAPE_CIRCLE, 300, -400, 500, 1000, 0), 0, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, 100, 0, 0, 0, 0,
                                   SHAPE_CIRCLE, 100, 0, 0, 0, 0), 0, none_c});
    // circle beside a box, both orders
    directed.push_back('{make_pair(SHAPE_CIRCLE, 1200, 300, 7, 500, 0,
                                   SHAPE_RECT, 0, 0, 0, 2000, 1000), 0, none_c});
    directed.push_back('{make_pair(SHAPE_RECT, 0, 0, 0, 2000, 1000,
                                   SHAPE_CIRCLE, -1100, -600, 9, 500, 0), 0, none_c});
    // centre inside the box: box-centre normal, then +x when concentric
    directed.push_back('{make_pair(SHAPE_CIRCLE, 100, 50, 30, 400, 0,
                                   SHAPE_RECT, 0, 0, 0, 2000, 1000), 0, none_c});
    directed.push_back('{make_pair(SHAPE_RECT, 0, 0, 0, 2000, 1000,
                                   SHAPE_CIRCLE, 0, 0, 0, 400, 0), 0, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, 8388607, -8388608, 8388607, 24'hFFFFFF, 0,
                                   SHAPE_RECT, -8388608, 8388607, -8388608, 24'hFFFFFF,
                                   24'hFFFFFF), 0, none_c});
    directed.push_back('{make_pair(SHAPE_RECT, 8388607, 8388607, 0, 0, 0,
                                   SHAPE_CIRCLE, 8388607, 8388607, 0, 1, 24'hFFFFFF),
                         0, none_c});
    directed.push_back('{make_pair(SHAPE_CIRCLE, 2, 1, 0, 300, 24'hFFFFFF,
                                   SHAPE_CIRCLE, 0, 0, 1, 300, 24'hFFFFFF), 0, none_c});

    limits[0] = 8'd0;
    limits[1] = 8'd255;
    limits[2] = LIMIT_W'($urandom);
    limits[3] = 8'd1;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      case (ph)
        0: begin idle_set = 0;  stall_set = 0;  end
        1: begin idle_set = 81; stall_set = 0;  end
        2: begin idle_set = 0;  stall_set = 81; end
        default: begin idle_set = 9; stall_set = 9; end
      endcase
      sender_idle_pct = idle_set;
      stall_pct = stall_set;
      if (ph == 0) begin
        foreach (directed[i]) send_pair(directed[i].pair, directed[i].typed, directed[i].want);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // short full bursts with no idling now and then
        if (n % 60 >= 30 && n % 60 < 40) begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end else begin
          sender_idle_pct = idle_set;
          stall_pct = stall_set;
        end
        send_pair(($urandom_range(9) == 0) ? noise_pair() : close_pair(), 0, none_c);
      end
      // hold off until every contact is back
      drain();
    end

    if (mismatches == 0) begin
      $display("circle_circle_aabb_contact_test test passed");
    end else begin
      $display("circle_circle_aabb_contact_test test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ccat_pkg.sv
src/ccat_sqrt.sv
src/ccat_div.sv
src/circle_circle_aabb_contact_test.sv
dv/circle_circle_aabb_contact_test_tb.sv
